FILE: sv/hsm_pkg.sv
// Shared constants for the halves sort-and-merge block.
`timescale 1ns / 1ps

package hsm_pkg;

    localparam int MAX_LEN = 32;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int AW      = $clog2(MAX_LEN);
    localparam int DATA_W  = 32;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [AW-1:0]     addr_t;
    typedef logic [DATA_W-1:0] word_t;

endpackage

FILE: sv/halves_sort_and_merge.sv
// Top level: list loader, per-half selection sort and merge.
//
//  channel | dir | payload                                  | handshake
//  s_      | in  | tdata[31:0] value, tlast final_element    | s_tvalid/s_tready
//  m_      | out | tdata[31:0] sorted_value, tlast           | m_tvalid/m_tready
//          |     | end_of_list, tuser overflowed            |
//
// Loading takes one cycle per transaction. After the final one, each half of
// n entries is sorted with one element store read per cycle, then the merge
// emits the results in order, reading the next element from the store after
// each result. s_tready is low from the final input until the last result
// is loaded into the output register.
// Reset (aresetn low, synchronous) clears count, overflow flag, output valid and state.
// A stalled m_ side holds the merge; the output register frees the loader.
`timescale 1ns / 1ps

module halves_sort_and_merge
    import hsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,
    output logic        m_tuser    // [0] overflowed
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SEL_START = 4'd1;
    localparam logic [3:0] ST_SEL_FIRST = 4'd2;
    localparam logic [3:0] ST_SCAN      = 4'd3;
    localparam logic [3:0] ST_SWAP1     = 4'd4;
    localparam logic [3:0] ST_SWAP2     = 4'd5;
    localparam logic [3:0] ST_MRG_L     = 4'd6;
    localparam logic [3:0] ST_MRG_H     = 4'd7;
    localparam logic [3:0] ST_EMIT      = 4'd8;
    localparam logic [3:0] ST_FILL      = 4'd9;

    word_t mem [MAX_LEN];

    logic [3:0] state_reg, state_next;
    cnt_t  count_reg, count_next;
    logic  dropped_reg, dropped_next;
    logic  half_reg, half_next;
    cnt_t  i_reg, i_next;
    cnt_t  j_reg, j_next;
    cnt_t  midx_reg, midx_next;
    word_t cur_reg, cur_next;
    word_t min_reg, min_next;
    word_t lo_reg, lo_next;
    word_t hi_reg, hi_next;
    cnt_t  li_reg, li_next;
    cnt_t  ri_reg, ri_next;
    cnt_t  k_reg, k_next;
    logic  took_lo_reg, took_lo_next;
    word_t rdata_reg;
    logic  m_valid_reg, m_valid_next;
    word_t m_data_reg, m_data_next;
    logic  m_last_reg, m_last_next;
    logic  m_user_reg, m_user_next;

    logic  we;
    addr_t wa, ra;
    word_t wd;
    cnt_t  half_len, nh, base, len;
    logic  s_fire, out_free, take_lo, last_out;

    function automatic addr_t to_addr(input cnt_t x);
        return x[AW-1:0];
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    assign half_len = count_reg >> 1;
    assign nh       = count_reg - half_len;
    assign base     = half_reg ? half_len : '0;
    assign len      = half_reg ? nh : half_len;
    assign out_free = !m_valid_reg || m_tready;
    assign take_lo  = (li_reg < half_len) &&
                      ((ri_reg >= nh) || ($signed(lo_reg) < $signed(hi_reg)));
    assign last_out = ((k_reg + cnt_t'(1)) == count_reg);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        half_next    = half_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        midx_next    = midx_reg;
        cur_next     = cur_reg;
        min_next     = min_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        li_next      = li_reg;
        ri_next      = ri_reg;
        k_next       = k_reg;
        took_lo_next = took_lo_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        we = 1'b0;
        wa = '0;
        wd = s_tdata;
        ra = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (count_reg < cnt_t'(MAX_LEN)) begin
                        we         = 1'b1;
                        wa         = to_addr(count_reg);
                        count_next = count_reg + cnt_t'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = ST_SEL_START;
                        half_next  = 1'b0;
                        i_next     = '0;
                    end
                end
            end
            ST_SEL_START: begin
                if ((i_reg + cnt_t'(1)) < len) begin
                    ra         = to_addr(base + i_reg);
                    state_next = ST_SEL_FIRST;
                end else if (!half_reg) begin
                    half_next = 1'b1;
                    i_next    = '0;
                end else begin
                    ra         = '0;
                    li_next    = '0;
                    ri_next    = '0;
                    k_next     = '0;
                    state_next = ST_MRG_L;
                end
            end
            ST_SEL_FIRST: begin
                cur_next   = rdata_reg;
                min_next   = rdata_reg;
                midx_next  = i_reg;
                j_next     = i_reg + cnt_t'(1);
                ra         = to_addr(base + i_reg + cnt_t'(1));
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if ($signed(rdata_reg) < $signed(min_reg)) begin
                    min_next  = rdata_reg;
                    midx_next = j_reg;
                end
                if ((j_reg + cnt_t'(1)) < len) begin
                    ra     = to_addr(base + j_reg + cnt_t'(1));
                    j_next = j_reg + cnt_t'(1);
                end else begin
                    state_next = ST_SWAP1;
                end
            end
            ST_SWAP1: begin
                we         = 1'b1;
                wa         = to_addr(base + midx_reg);
                wd         = cur_reg;
                state_next = ST_SWAP2;
            end
            ST_SWAP2: begin
                we         = 1'b1;
                wa         = to_addr(base + i_reg);
                wd         = min_reg;
                i_next     = i_reg + cnt_t'(1);
                state_next = ST_SEL_START;
            end
            ST_MRG_L: begin
                lo_next    = rdata_reg;
                ra         = to_addr(half_len);
                state_next = ST_MRG_H;
            end
            ST_MRG_H: begin
                hi_next    = rdata_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = take_lo ? lo_reg : hi_reg;
                    m_last_next  = last_out;
                    m_user_next  = dropped_reg;
                    k_next       = k_reg + cnt_t'(1);
                    took_lo_next = take_lo;
                    if (take_lo) begin
                        li_next = li_reg + cnt_t'(1);
                        ra      = to_addr(li_reg + cnt_t'(1));
                    end else begin
                        ri_next = ri_reg + cnt_t'(1);
                        ra      = to_addr(half_len + ri_reg + cnt_t'(1));
                    end
                    if (last_out) begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                if (took_lo_reg) begin
                    lo_next = rdata_reg;
                end else begin
                    hi_next = rdata_reg;
                end
                state_next = ST_EMIT;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rdata_reg <= mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
        half_reg    <= half_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        midx_reg    <= midx_next;
        cur_reg     <= cur_next;
        min_reg     <= min_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        li_reg      <= li_next;
        ri_reg      <= ri_next;
        k_reg       <= k_next;
        took_lo_reg <= took_lo_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
        m_user_reg  <= m_user_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cnt_t'(MAX_LEN))
        else $error("element count above capacity");

    a_out_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result loaded outside merge");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && last_out)
            |=> (count_reg == '0 && !dropped_reg && state_reg == ST_IDLE))
        else $error("list state not cleared after last result");

    a_merge_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (li_reg <= half_len && ri_reg <= nh))
        else $error("merge index past its half");
`endif

endmodule
